/* hw/rtl/ltr_pkg.sv */
package ltr_pkg;

	localparam int SAMPLE_WIDTH_DEF = 24;
	localparam int PHASE_WIDTH_DEF = 32;
	localparam int SINE_ENTRIES_DEF = 256;

	localparam int CFG_W = 32;
	localparam int CFG_IDX_W = 2;
	localparam int LFO_W = 17;
	localparam int DEPTH_W = 16;

	// register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_PHASE_INC = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DEPTH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WAVEFORM = 2'd2;

	localparam logic [31:0] PHASE_INC_RST = 32'd194784;
	localparam logic [DEPTH_W-1:0] DEPTH_FULL = 16'd32768;

	// waveform codes
	localparam logic [1:0] WAVE_SINE = 2'd0;
	localparam logic [1:0] WAVE_TRIANGLE = 2'd1;
	localparam logic [1:0] WAVE_SQUARE = 2'd2;
	localparam logic [1:0] WAVE_SLOPED = 2'd3;

	// pi/2 in Q30
	localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;

	typedef struct packed {
		logic [1:0]  shape;
		logic [15:0] phase;
	} lfo_req_t;

	// next taylor term before its divisor: two truncating Q30 products by x
	function automatic longint unsigned taylor_next(input longint unsigned term,
			input longint unsigned x);
		longint unsigned t;
		t = (term * x) >> 30;
		return (t * x) >> 30;
	endfunction

	// 32768*sin(x) for x in Q30, Taylor series up to x^15, rounded
	function automatic logic [15:0] sine_taylor(input longint unsigned x);
		longint unsigned term;
		longint sum;
		longint unsigned e;
		term = x;
		sum = longint'(x);
		// divisors are (2k)(2k+1), signs alternate
		term = taylor_next(term, x) / 64'd6;
		sum = sum - longint'(term);
		term = taylor_next(term, x) / 64'd20;
		sum = sum + longint'(term);
		term = taylor_next(term, x) / 64'd42;
		sum = sum - longint'(term);
		term = taylor_next(term, x) / 64'd72;
		sum = sum + longint'(term);
		term = taylor_next(term, x) / 64'd110;
		sum = sum - longint'(term);
		term = taylor_next(term, x) / 64'd156;
		sum = sum + longint'(term);
		term = taylor_next(term, x) / 64'd210;
		sum = sum - longint'(term);
		if (sum < 0) begin
			sum = 0;
		end
		e = (longint'(sum) + 64'd16384) >> 15;
		if (e > 64'd32768) begin
			e = 64'd32768;
		end
		return e[15:0];
	endfunction

endpackage

/* hw/rtl/lfo_tremolo.sv */
// channel  | handshake             | payload
// ---------+-----------------------+-------------------------------------
// input    | in_valid / in_ready   | sample_in  (SAMPLE_WIDTH, signed)
// output   | out_valid / out_ready | sample_out (SAMPLE_WIDTH, signed)
// config   | cfg_we                | cfg_index (2), cfg_data (32)
//
// one sample runs through the table, gain, multiply and done steps before the
// next is accepted: the shared multiplier is used three times (sine index,
// depth*lfo, sample*gain) and the rounded result is formed in a final step
// in_ready is high only while the sequencer idles
// the result lands in an output register, so a stalled output delays the
// sequencer only when a second result is finished before the first is taken
// asynchronous reset clears the lfo phase and loads the register defaults
module lfo_tremolo #(
	parameter int SAMPLE_WIDTH = ltr_pkg::SAMPLE_WIDTH_DEF,
	parameter int PHASE_WIDTH = ltr_pkg::PHASE_WIDTH_DEF,
	parameter int SINE_QUARTER_ENTRIES = ltr_pkg::SINE_ENTRIES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [SAMPLE_WIDTH-1:0]      sample_in,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [SAMPLE_WIDTH-1:0]      sample_out,
	input  logic                                cfg_we,
	input  logic [ltr_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [ltr_pkg::CFG_W-1:0]           cfg_data
);

	localparam int IDX_W = $clog2(SINE_QUARTER_ENTRIES + 1);
	// operand width: wide enough for the sample and for a gain up to 2^31
	localparam int MW = (SAMPLE_WIDTH + 1 > 33) ? SAMPLE_WIDTH + 1 : 33;

	// sequencer states
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_TAB  = 3'd1;
	localparam logic [2:0] ST_GAIN = 3'd2;
	localparam logic [2:0] ST_MUL  = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	localparam logic signed [MW-1:0] GAIN_ONE = MW'(64'd1 << 31);
	localparam logic signed [2*MW-1:0] ROUND_HALF = (2*MW)'(64'd1 << 30);

	logic [2:0] state_q;

	// configuration registers
	logic [31:0]                  phase_inc_q;
	logic [ltr_pkg::DEPTH_W-1:0]  depth_q;
	logic [1:0]                   wave_q;

	logic [PHASE_WIDTH-1:0]       phase_q;
	logic [15:0]                  p_q;
	logic signed [SAMPLE_WIDTH-1:0] x_q;

	logic                         accept;
	logic                         out_free;
	logic [15:0]                  p_now;
	logic [PHASE_WIDTH+31:0]      phase_sum;

	logic                         mul_en;
	logic signed [MW-1:0]         mul_a;
	logic signed [MW-1:0]         mul_b;
	logic signed [2*MW-1:0]       prod_q;

	logic [IDX_W-1:0]             k;
	logic [IDX_W-1:0]             idx;
	logic                         lfo_en;
	ltr_pkg::lfo_req_t            lfo_req;
	logic [ltr_pkg::LFO_W-1:0]    lfo_q;

	logic [ltr_pkg::DEPTH_W-1:0]  depth_eff;
	logic signed [2*MW-1:0]       rounded;

	assign in_ready = (state_q == ST_IDLE);
	assign accept = in_valid && in_ready;
	// output slot can take a new result this cycle
	assign out_free = !out_valid || out_ready;

	// current phase as unsigned q0.16
	assign p_now = phase_q[PHASE_WIDTH-1 -: 16];
	assign phase_sum = (PHASE_WIDTH+32)'(phase_q) + (PHASE_WIDTH+32)'(phase_inc_q);

	// depth above full saturates
	assign depth_eff = (depth_q > ltr_pkg::DEPTH_FULL) ? ltr_pkg::DEPTH_FULL : depth_q;

	// sine index from the registered product frac*N, mirrored in odd quadrants
	assign k = prod_q[14 +: IDX_W];
	assign idx = p_q[14] ? (IDX_W'(SINE_QUARTER_ENTRIES) - k) : k;

	assign lfo_req.shape = wave_q;
	assign lfo_req.phase = p_q;
	assign lfo_en = (state_q == ST_TAB);

	// operand select for the shared multiplier
	always_comb begin
		mul_en = 1'b0;
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_IDLE: begin
				mul_en = accept;
				mul_a = MW'(p_now[13:0]);
				mul_b = MW'(SINE_QUARTER_ENTRIES);
			end
			ST_GAIN: begin
				mul_en = 1'b1;
				mul_a = MW'(depth_eff);
				mul_b = MW'(lfo_q);
			end
			ST_MUL: begin
				// gain = 1 - depth*lfo in q31
				mul_en = 1'b1;
				mul_a = MW'(x_q);
				mul_b = GAIN_ONE - prod_q[MW-1:0];
			end
			ST_TAB, ST_DONE: begin
				mul_en = 1'b0;
			end
			default: begin
				mul_en = 1'b0;
			end
		endcase
	end

	// round to nearest, ties toward plus infinity
	assign rounded = (prod_q + ROUND_HALF) >>> 31;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_inc_q <= ltr_pkg::PHASE_INC_RST;
			depth_q <= ltr_pkg::DEPTH_FULL;
			wave_q <= ltr_pkg::WAVE_SINE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ltr_pkg::REG_PHASE_INC: phase_inc_q <= cfg_data;
				ltr_pkg::REG_DEPTH: depth_q <= cfg_data[ltr_pkg::DEPTH_W-1:0];
				ltr_pkg::REG_WAVEFORM: wave_q <= cfg_data[1:0];
				default: begin
					// unknown index ignored
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= '0;
			out_valid <= 1'b0;
		end else begin
			// a finished result refills the slot, otherwise a taken one empties it
			if (state_q == ST_DONE && out_free) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						// sample uses the phase before the increment
						phase_q <= phase_sum[PHASE_WIDTH-1:0];
						state_q <= ST_TAB;
					end
				end
				ST_TAB: state_q <= ST_GAIN;
				ST_GAIN: state_q <= ST_MUL;
				ST_MUL: state_q <= ST_DONE;
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			x_q <= sample_in;
			p_q <= p_now;
		end
		if (state_q == ST_DONE && out_free) begin
			sample_out <= rounded[SAMPLE_WIDTH-1:0];
		end
	end

	ltr_mul #(
		.MW(MW)
	) u_mul (
		.clk   (clk),
		.en    (mul_en),
		.a     (mul_a),
		.b     (mul_b),
		.prod_q(prod_q)
	);

	ltr_lfo #(
		.SINE_QUARTER_ENTRIES(SINE_QUARTER_ENTRIES)
	) u_lfo (
		.clk  (clk),
		.en   (lfo_en),
		.req  (lfo_req),
		.idx  (idx),
		.lfo_q(lfo_q)
	);

`ifndef SYNTHESIS
	// an accepted transaction starts the table step
	a_accept_to_tab: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_TAB))
		else $error("accepted transaction did not start the sequence");

	// a new result appears only out of the final step
	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_DONE))
		else $error("output valid rose outside the final step");

	// a finished result waits while the output slot is occupied
	a_done_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && out_valid && !out_ready) |=> (state_q == ST_DONE))
		else $error("result overwrote a pending output");

	// the lfo phase advances only with an accepted transaction
	a_phase_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> $stable(phase_q))
		else $error("lfo phase moved without a transaction");
`endif

endmodule

/* hw/rtl/ltr_mul.sv */
module ltr_mul #(
	parameter int MW = 33
) (
	input  logic                   clk,
	input  logic                   en,
	input  logic signed [MW-1:0]   a,
	input  logic signed [MW-1:0]   b,
	output logic signed [2*MW-1:0] prod_q
);

	// shared signed multiplier, product registered
	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= a * b;
		end
	end

endmodule

/* hw/rtl/ltr_lfo.sv */
module ltr_lfo #(
	parameter int SINE_QUARTER_ENTRIES = ltr_pkg::SINE_ENTRIES_DEF,
	localparam int IDX_W = $clog2(SINE_QUARTER_ENTRIES + 1)
) (
	input  logic                         clk,
	input  logic                         en,
	input  ltr_pkg::lfo_req_t            req,
	input  logic [IDX_W-1:0]             idx,
	output logic [ltr_pkg::LFO_W-1:0]    lfo_q
);

	// quarter-wave sine table, worked out at elaboration
	logic [15:0] sine_tab [SINE_QUARTER_ENTRIES+1];

	for (genvar gi = 0; gi <= SINE_QUARTER_ENTRIES; gi++) begin : g_tab
		localparam longint unsigned X =
			(ltr_pkg::PI_HALF_Q30 * longint'(gi)) / SINE_QUARTER_ENTRIES;
		assign sine_tab[gi] = ltr_pkg::sine_taylor(X);
	end

	logic [15:0] p;
	logic [17:0] p2;
	logic [22:0] p50;
	logic [15:0] tab_val;
	logic [ltr_pkg::LFO_W-1:0] lfo_d;

	assign p = req.phase;
	assign p2 = {1'b0, p, 1'b0};
	assign p50 = 23'(p) * 23'd50;
	assign tab_val = sine_tab[idx];

	always_comb begin
		case (req.shape)
			ltr_pkg::WAVE_TRIANGLE: begin
				if (p < 16'd16384) begin
					lfo_d = 17'(18'd32768 + p2);
				end else if (p < 16'd49152) begin
					lfo_d = 17'(18'd98304 - p2);
				end else begin
					lfo_d = 17'(p2 - 18'd98304);
				end
			end
			ltr_pkg::WAVE_SQUARE: begin
				lfo_d = (p < 16'd32768) ? 17'd65536 : 17'd0;
			end
			ltr_pkg::WAVE_SLOPED: begin
				if (p <= 16'd31457) begin
					lfo_d = 17'd65536;
				end else if (p < 16'd32768) begin
					lfo_d = 17'(23'd1638400 - p50);
				end else if (p <= 16'd64225) begin
					lfo_d = 17'd0;
				end else begin
					lfo_d = 17'(p50 - 23'd3211264);
				end
			end
			default: begin
				// sine: first half of the cycle adds, second half subtracts
				if (p[15]) begin
					lfo_d = 17'd32768 - 17'(tab_val);
				end else begin
					lfo_d = 17'd32768 + 17'(tab_val);
				end
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lfo_q <= lfo_d;
		end
	end

endmodule
